@@ sv/rgb_to_hsv_converter_assert.svh @@
// assertion macros used by the rgb to hsv back end (rhc_back)
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// same-cycle implication
`define RHC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rgb_to_hsv_converter assertion failed");

// next-cycle implication
`define RHC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rgb_to_hsv_converter assertion failed");

`endif

@@ sv/rhc_pkg.sv @@
package rhc_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int SAT_STEPS   = 17;
    localparam int HUE_STEPS   = 12;

    localparam logic [14:0] HUE_TWO_SIXTHS  = 15'd7680;
    localparam logic [14:0] HUE_FOUR_SIXTHS = 15'd15360;
    localparam logic [14:0] HUE_FULL        = 15'd23040;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    typedef struct packed {
        logic [7:0]  mx;
        logic [7:0]  diff;
        logic [19:0] hue_dividend;
        logic        neg;
        sector_t     sector;
    } rhc_item_t;

endpackage

@@ sv/rhc_front.sv @@
module rhc_front (
    input  logic [23:0]       pixel,
    output rhc_pkg::rhc_item_t item
);
    import rhc_pkg::*;

    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] mx;
    logic [7:0] mn;
    logic [7:0] mag;

    assign r = pixel[7:0];
    assign g = pixel[15:8];
    assign b = pixel[23:16];

    always_comb begin
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        item.neg = 1'b0;
        mag = 8'd0;
        if (r >= g && r >= b) begin
            mx = r;
            item.sector = SECT_RED;
            item.neg = (g < b);
            mag = (g < b) ? (b - g) : (g - b);
        end else if (g >= b) begin
            mx = g;
            item.sector = SECT_GREEN;
            item.neg = (b < r);
            mag = (b < r) ? (r - b) : (b - r);
        end else begin
            mx = b;
            item.sector = SECT_BLUE;
            item.neg = (r < g);
            mag = (r < g) ? (g - r) : (r - g);
        end
        item.mx = mx;
        item.diff = mx - mn;
        // 3840 * mag as 4096 * mag - 256 * mag
        item.hue_dividend = {mag, 12'd0} - {4'd0, mag, 8'd0};
    end

endmodule

@@ sv/rhc_queue.sv @@
module rhc_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  rhc_pkg::rhc_item_t push_item,
    output logic               pop_valid,
    input  logic               pop,
    output rhc_pkg::rhc_item_t pop_item
);
    import rhc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rhc_item_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ sv/rhc_back.sv @@
module rhc_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_valid,
    input  rhc_pkg::rhc_item_t item,
    output logic               item_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [14:0]        hue,
    output logic [16:0]        saturation,
    output logic [7:0]         brightness
);
    import rhc_pkg::*;

    `include "rgb_to_hsv_converter_assert.svh"

    typedef struct packed {
        rhc_item_t   itm;
        logic [7:0]  sat_rem;
        logic [16:0] sat_bits;
        logic [16:0] sat_q;
        logic [7:0]  hue_rem;
        logic [11:0] hue_bits;
        logic [11:0] hue_q;
    } div_stage_t;

    function automatic div_stage_t div_init(rhc_item_t it);
        div_stage_t s;
        s.itm      = it;
        s.sat_rem  = {1'b0, it.diff[7:1]};
        s.sat_bits = {it.diff[0], 16'd0};
        s.sat_q    = '0;
        s.hue_rem  = it.hue_dividend[19:12];
        s.hue_bits = it.hue_dividend[11:0];
        s.hue_q    = '0;
        return s;
    endfunction

    function automatic div_stage_t div_step(div_stage_t s, logic do_hue);
        div_stage_t o;
        logic [8:0] st;
        logic [8:0] ht;
        o  = s;
        st = {s.sat_rem, s.sat_bits[16]};
        if (st >= {1'b0, s.itm.mx}) begin
            st = st - {1'b0, s.itm.mx};
            o.sat_q = {s.sat_q[15:0], 1'b1};
        end else begin
            o.sat_q = {s.sat_q[15:0], 1'b0};
        end
        o.sat_rem  = st[7:0];
        o.sat_bits = {s.sat_bits[15:0], 1'b0};
        if (do_hue) begin
            ht = {s.hue_rem, s.hue_bits[11]};
            if (ht >= {1'b0, s.itm.diff}) begin
                ht = ht - {1'b0, s.itm.diff};
                o.hue_q = {s.hue_q[10:0], 1'b1};
            end else begin
                o.hue_q = {s.hue_q[10:0], 1'b0};
            end
            o.hue_rem  = ht[7:0];
            o.hue_bits = {s.hue_bits[10:0], 1'b0};
        end
        return o;
    endfunction

    div_stage_t  stg_reg       [SAT_STEPS];
    logic        stg_valid_reg [SAT_STEPS];
    div_stage_t  stg_in        [SAT_STEPS];
    div_stage_t  stg_next      [SAT_STEPS];
    logic        stg_valid_in  [SAT_STEPS];
    logic        advance;
    logic        out_valid_reg;
    logic [14:0] hue_reg;
    logic [16:0] sat_reg;
    logic [7:0]  bri_reg;
    logic [14:0] hue_next;
    logic [16:0] sat_next;
    logic [14:0] q_ext;
    div_stage_t  last;

    assign advance  = !out_valid_reg || out_ready;
    assign item_pop = advance && item_valid;

    for (genvar g = 0; g < SAT_STEPS; g++) begin : g_stage
        if (g == 0) begin : g_first
            assign stg_in[g]       = div_init(item);
            assign stg_valid_in[g] = item_valid;
        end else begin : g_rest
            assign stg_in[g]       = stg_reg[g-1];
            assign stg_valid_in[g] = stg_valid_reg[g-1];
        end
        assign stg_next[g] = div_step(stg_in[g], (g < HUE_STEPS));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stg_valid_reg[g] <= 1'b0;
            end else if (advance) begin
                stg_valid_reg[g] <= stg_valid_in[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                stg_reg[g] <= stg_next[g];
            end
        end
    end

    assign last  = stg_reg[SAT_STEPS-1];
    assign q_ext = {3'd0, last.hue_q};

    always_comb begin
        sat_next = (last.itm.mx == 8'd0) ? 17'd0 : last.sat_q;
        case (last.itm.sector)
            SECT_RED: begin
                if (last.itm.neg && q_ext != 15'd0) begin
                    hue_next = HUE_FULL - q_ext;
                end else begin
                    hue_next = q_ext;
                end
            end
            SECT_GREEN: begin
                hue_next = last.itm.neg ? (HUE_TWO_SIXTHS - q_ext) : (HUE_TWO_SIXTHS + q_ext);
            end
            SECT_BLUE: begin
                hue_next = last.itm.neg ? (HUE_FOUR_SIXTHS - q_ext)
                                        : (HUE_FOUR_SIXTHS + q_ext);
            end
            default: begin
                hue_next = 15'd0;
            end
        endcase
        if (last.itm.diff == 8'd0) begin
            hue_next = 15'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= stg_valid_reg[SAT_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            bri_reg <= last.itm.mx;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bri_reg;

    `RHC_ASSERT_IMP(a_sat_range, aclk, aresetn, out_valid_reg, sat_reg <= 17'd65536)
    `RHC_ASSERT_IMP(a_hue_range, aclk, aresetn, out_valid_reg, hue_reg < HUE_FULL)
    `RHC_ASSERT_IMP(a_black_zero, aclk, aresetn, out_valid_reg && bri_reg == 8'd0,
                    sat_reg == 17'd0 && hue_reg == 15'd0)
    `RHC_ASSERT_NXT(a_last_to_out, aclk, aresetn, advance && stg_valid_reg[SAT_STEPS-1],
                    out_valid_reg)

endmodule

@@ sv/rgb_to_hsv_converter.sv @@
// rgb to hsv conversion of a pixel stream, one result item per input item
// s_ channel: one 24-bit rgb pixel (8 bits per colour) per item
// m_ channel: hue in 1/64 degree, saturation in q1.16, value (channel max)
// front: max/min, sector and hue dividend, pushed into a 4-entry queue
// back: 17-stage pipelined restoring divider, one quotient bit per stage
//   for saturation and for hue (hue done after 12 stages), then an
//   output register with the sector offset and wrap
// throughput: one item per cycle through the pipelined divider while m_tready does not stall the output
// reset: queue, stage valids and output valid clear; no other state
// receiver stall: the divider pipeline and output register hold, the
//   queue fills and s_tready drops once its 4 entries are taken
module rgb_to_hsv_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // hue[14:0], saturation[31:15], brightness[39:32]
);
    import rhc_pkg::*;

    rhc_item_t   front_item;
    rhc_item_t   head_item;
    logic        head_valid;
    logic        head_pop;
    logic [14:0] hue;
    logic [16:0] saturation;
    logic [7:0]  brightness;

    rhc_front u_front (
        .pixel (s_tdata),
        .item  (front_item)
    );

    rhc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_item  (front_item),
        .pop_valid  (head_valid),
        .pop        (head_pop),
        .pop_item   (head_item)
    );

    rhc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (head_valid),
        .item       (head_item),
        .item_pop   (head_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    assign m_tdata = {brightness, saturation, hue};

endmodule
